FILE: hw/rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  localparam int PATTERN_CHARS_DEF = 64;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_EMPTY  = 2'd3
  } wgm_op_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic       restart;
    logic       step;
    logic       wr;
    logic [7:0] data;
  } wgm_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wgm_if.sv
// ----------------------------------------------------------------------------
// wgm_if
// Valid/ready channels of the glob matcher: command beats in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output opcode, output byte_value, output last_byte,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input last_byte,
                  output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic truncated;

  modport source (output valid, output matched, output truncated, input ready);
  modport sink   (input valid, input matched, input truncated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte and its active bit, and
// hands a match forward to the next position on every text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wgm_pkg::wgm_ctl_t   ctl,
  input  logic [LW-1:0]       clen,
  input  logic                prev_act,
  input  logic                prev_star,
  input  logic                prev_fwd,
  input  logic                prev_actn,
  output logic                act,
  output logic                star,
  output logic                fwd,
  output logic                actn,
  output logic                hit
);
  import wgm_pkg::*;

  localparam logic [LW-1:0] IDX_L = LW'(IDX);

  logic [7:0] pat_r;
  logic       act_r;
  logic       act_nxt;
  logic       valid;
  logic       closed;
  logic       closed_n;

  always_ff @(posedge clk) begin
    if (ctl.wr && clen == IDX_L) begin
      pat_r <= ctl.data;
    end
  end

  always_comb begin
    valid    = IDX_L < clen;
    star     = valid && (pat_r == STAR_BYTE);
    closed   = act_r || (prev_act && prev_star);
    fwd      = closed && valid && !star &&
               ((pat_r == QMARK_BYTE) || (pat_r == ctl.data));
    actn     = (closed && star) || prev_fwd;
    closed_n = actn || (prev_actn && prev_star);
    hit      = closed_n && (clen == IDX_L);
    act      = act_r;
    if (ctl.restart) begin
      act_nxt = (IDX == 0);
    end else if (ctl.step) begin
      act_nxt = actn;
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (IDX == 0);
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Glob matcher ('*' any run, '?' any byte) over a row of position cells.
// ----------------------------------------------------------------------------
//   channel | dir | beat contents
//   in_ch   | in  | opcode, byte_value, last_byte
//   out_ch  | out | matched, truncated
//
// One beat per cycle, every opcode, unless a stalled result holds in_ch off; a result appears the cycle after its beat.
// All pattern positions update together, so the rate does not depend on the pattern length.
// Runs of '*' are folded to one on load, so star closure spans one cell.
// Reset leaves an empty pattern; pattern bytes need no clearing.
// A stalled result holds in_ch off only while out_ch is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher #(
  parameter int PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wgm_in_if.sink    in_ch,
  wgm_out_if.source out_ch
);
  import wgm_pkg::*;

  localparam int            N  = PATTERN_CHARS;
  localparam int            LW = $clog2(N + 1);
  localparam logic [LW-1:0] N_L = LW'(N);

  logic [LW-1:0] raw_len_r, raw_len_nxt;
  logic [LW-1:0] clen_r, clen_nxt;
  logic          last_star_r, last_star_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          matched_r, matched_nxt;
  logic          trunc_r, trunc_nxt;

  wgm_ctl_t ctl;
  wgm_op_t  op;
  logic     accept;
  logic     emit;
  logic     end_hit;
  logic     text_match;
  logic     is_star;

  logic [N-1:0] act_w, star_w, fwd_w, actn_w, hit_w;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
        wgm_cell #(.IDX(g), .LW(LW)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .clen(clen_r),
          .prev_act(1'b0), .prev_star(1'b0), .prev_fwd(1'b0), .prev_actn(1'b0),
          .act(act_w[g]), .star(star_w[g]), .fwd(fwd_w[g]),
          .actn(actn_w[g]), .hit(hit_w[g])
        );
      end else begin : g_rest
        wgm_cell #(.IDX(g), .LW(LW)) u_cell (
          .clk(clk), .rst_n(rst_n), .ctl(ctl), .clen(clen_r),
          .prev_act(act_w[g-1]), .prev_star(star_w[g-1]),
          .prev_fwd(fwd_w[g-1]), .prev_actn(actn_w[g-1]),
          .act(act_w[g]), .star(star_w[g]), .fwd(fwd_w[g]),
          .actn(actn_w[g]), .hit(hit_w[g])
        );
      end
    end
  endgenerate

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = wgm_op_t'(in_ch.opcode);
  assign is_star     = (in_ch.byte_value == STAR_BYTE);

  // Final position: reached from the last cell, or by closure over a trailing star
  assign end_hit    = (fwd_w[N-1] || (actn_w[N-1] && star_w[N-1])) && (clen_r == N_L);
  assign text_match = (|hit_w) || end_hit;

  always_comb begin
    ctl           = '0;
    ctl.data      = in_ch.byte_value;
    raw_len_nxt   = raw_len_r;
    clen_nxt      = clen_r;
    last_star_nxt = last_star_r;
    ovf_nxt       = ovf_r;
    emit          = 1'b0;
    matched_nxt   = matched_r;
    trunc_nxt     = trunc_r;
    if (accept) begin
      case (op)
        OP_CLEAR: begin
          ctl.restart   = 1'b1;
          raw_len_nxt   = '0;
          clen_nxt      = '0;
          last_star_nxt = 1'b0;
          ovf_nxt       = 1'b0;
        end
        OP_APPEND: begin
          ctl.restart = 1'b1;
          if (raw_len_r < N_L) begin
            raw_len_nxt   = LW'(raw_len_r + 1'b1);
            last_star_nxt = is_star;
            if (!(is_star && last_star_r)) begin
              ctl.wr   = 1'b1;
              clen_nxt = LW'(clen_r + 1'b1);
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_TEXT: begin
          ctl.step = 1'b1;
          if (in_ch.last_byte) begin
            ctl.restart = 1'b1;
            emit        = 1'b1;
            matched_nxt = text_match;
            trunc_nxt   = ovf_r;
          end
        end
        OP_EMPTY: begin
          ctl.restart = 1'b1;
          emit        = 1'b1;
          matched_nxt = (clen_r == '0) || ((clen_r == LW'(1)) && star_w[0]);
          trunc_nxt   = ovf_r;
        end
        default: begin
          ctl.restart = 1'b1;
        end
      endcase
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_len_r   <= '0;
      clen_r      <= '0;
      last_star_r <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_len_r   <= raw_len_nxt;
      clen_r      <= clen_nxt;
      last_star_r <= last_star_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
    trunc_r   <= trunc_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.matched   = matched_r;
  assign out_ch.truncated = trunc_r;

endmodule

`default_nettype wire

FILE: tb/sv/wildcard_glob_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_tb
// Self-checking bench for the glob matcher. A scoreboard class tracks the
// pattern and the live position set of its own and predicts a verdict for
// every finished text. Directed beats come first, then pattern loads with
// texts built to hit or nearly hit them, mixed with noise and abandoned texts.
// The sender bursts and pauses, and the receiver stalls on a pattern of its
// own, including one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam int NCHARS    = PATTERN_CHARS_DEF;
  localparam int ITEMS     = 1350;
  localparam int LONG_HOLD = 200;

  typedef struct {
    logic matched;
    logic truncated;
  } verdict_t;

  typedef bit [7:0] byte_q_t[$];

  class glob_scoreboard;
    bit [7:0]      pat_bytes [NCHARS];
    int unsigned   pat_len;
    bit [NCHARS:0] live;
    bit            trunc_seen;
    verdict_t      verdicts [$];
    int unsigned   failures;

    function new();
      pat_len    = 0;
      trunc_seen = 1'b0;
      failures   = 0;
      restart();
    endfunction

    function void restart();
      live    = '0;
      live[0] = 1'b1;
    endfunction

    // a live star also makes the following position live, chained forwards
    function void close_stars();
      for (int i = 0; i < pat_len; i++)
        if (live[i] && pat_bytes[i] == STAR_BYTE) live[i+1] = 1'b1;
    endfunction

    function void take_byte(bit [7:0] c);
      bit [NCHARS:0] nxt;
      nxt = '0;
      close_stars();
      for (int i = 0; i < pat_len; i++) begin
        if (live[i]) begin
          if (pat_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
          else if (pat_bytes[i] == QMARK_BYTE || pat_bytes[i] == c) nxt[i+1] = 1'b1;
        end
      end
      live = nxt;
    endfunction

    function void push_verdict();
      verdict_t v;
      close_stars();
      v.matched   = live[pat_len];
      v.truncated = trunc_seen;
      verdicts.insert(verdicts.size(), v);
      restart();
    endfunction

    function void note_beat(wgm_op_t op, bit [7:0] b, bit last);
      case (op)
        OP_CLEAR: begin
          pat_len    = 0;
          trunc_seen = 1'b0;
          restart();
        end
        OP_APPEND: begin
          if (pat_len < NCHARS) begin
            pat_bytes[pat_len] = b;
            pat_len++;
          end else begin
            trunc_seen = 1'b1;
          end
          restart();
        end
        OP_TEXT: begin
          take_byte(b);
          if (last) push_verdict();
        end
        default: begin
          restart();
          push_verdict();
        end
      endcase
    endfunction

    function void check_result(logic m, logic t);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result beat with no verdict pending: matched %b truncated %b", m, t);
        failures++;
        return;
      end
      v = verdicts.pop_front();
      if (m !== v.matched) begin
        $error("matched: expected %b, got %b", v.matched, m);
        failures++;
      end
      if (t !== v.truncated) begin
        $error("truncated: expected %b, got %b", v.truncated, t);
        failures++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wgm_in_if  in_ch ();
  wgm_out_if out_ch ();

  wildcard_glob_matcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glob_scoreboard sb = new();

  bit          hold_request = 1'b0;
  bit          no_gaps      = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned beats_sent   = 0;
  bit [7:0]    gen_pat [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_beat(wgm_op_t'(in_ch.opcode), in_ch.byte_value, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.matched, out_ch.truncated);
    end
  end

  // receiver: modes of random length, plus the long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
          2:       out_ch.ready <= ((mode_left % 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(wgm_op_t op, logic [7:0] b, logic last);
    if (!no_gaps && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.byte_value <= b;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    beats_sent++;
    if (op == OP_CLEAR) gen_pat.delete();
    else if (op == OP_APPEND && gen_pat.size() < NCHARS) gen_pat.insert(gen_pat.size(), b);
  endtask

  // sender holds back until every verdict has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic bit [7:0] pick_pat_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return STAR_BYTE;
    if (r == 2) return QMARK_BYTE;
    if (r == 3) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  function automatic bit [7:0] pick_text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  // text that fits the kept pattern, then sometimes knocked off by one byte
  task automatic make_text(output byte_q_t t);
    int pos;
    t = {};
    foreach (gen_pat[i]) begin
      if (gen_pat[i] == STAR_BYTE)
        repeat ($urandom_range(0, 3)) t.insert(t.size(), pick_text_byte());
      else if (gen_pat[i] == QMARK_BYTE) t.insert(t.size(), 8'($urandom_range(0, 255)));
      else t.insert(t.size(), gen_pat[i]);
    end
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 2))
        0: begin
          if (t.size() > 0) begin
            pos    = $urandom_range(0, t.size() - 1);
            t[pos] = pick_text_byte();
          end
        end
        1:       t.insert(t.size(), pick_text_byte());
        default: if (t.size() > 0) void'(t.pop_back());
      endcase
    end
  endtask

  task automatic send_text(byte_q_t t);
    int cut;
    if (t.size() == 0) begin
      send_beat(OP_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    cut = t.size();
    if (t.size() > 1 && $urandom_range(0, 19) == 0) cut = $urandom_range(1, t.size() - 1);
    for (int i = 0; i < cut; i++)
      send_beat(OP_TEXT, t[i], (i == t.size() - 1));
    if (cut < t.size()) begin
      case ($urandom_range(0, 2))
        0:       send_beat(OP_EMPTY, t[cut], 1'b1);
        1:       send_beat(OP_APPEND, pick_pat_byte(), 1'b1);
        default: send_beat(OP_CLEAR, t[cut], 1'b1);
      endcase
    end
  endtask

  task automatic load_pattern(int n);
    if ($urandom_range(0, 11) != 0) send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (n) send_beat(OP_APPEND, pick_pat_byte(), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_directed();
    send_beat(OP_EMPTY, 8'hFF, 1'b1);
    send_beat(OP_TEXT, 8'h00, 1'b1);
    send_beat(OP_APPEND, STAR_BYTE, 1'b0);
    send_beat(OP_EMPTY, 8'h00, 1'b0);
    send_beat(OP_TEXT, 8'hFF, 1'b1);
    send_beat(OP_CLEAR, 8'hFF, 1'b1);
    send_beat(OP_APPEND, "a", 1'b0);
    send_beat(OP_APPEND, QMARK_BYTE, 1'b0);
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_TEXT, 8'hFF, 1'b1);
    send_beat(OP_TEXT, "a", 1'b1);
    // dead automaton: first byte already kills every position
    send_beat(OP_TEXT, "b", 1'b0);
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_TEXT, "x", 1'b1);
    // pattern grows mid-text, the partial text is dropped
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_APPEND, "b", 1'b0);
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_TEXT, "z", 1'b0);
    send_beat(OP_TEXT, "b", 1'b1);
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_EMPTY, 8'h55, 1'b0);
    send_beat(OP_TEXT, "a", 1'b0);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    send_beat(OP_EMPTY, 8'hAA, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic apply_pressure();
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    send_beat(OP_APPEND, STAR_BYTE, 1'b0);
    repeat (20) begin
      send_beat(OP_EMPTY, 8'($urandom_range(0, 255)), 1'b0);
      send_beat(OP_TEXT, pick_text_byte(), 1'b1);
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    int          r;
    int          len;
    int unsigned next_drain;
    byte_q_t     txt;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_CLEAR;
    in_ch.byte_value <= 8'h00;
    in_ch.last_byte  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    apply_pressure();

    next_drain = beats_sent + $urandom_range(150, 300);
    while (beats_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_beat(wgm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) len = $urandom_range(60, 70);
        else if (r < 12) len = $urandom_range(16, 40);
        else len = $urandom_range(0, 8);
        load_pattern(len);
        repeat ($urandom_range(1, 6)) begin
          make_text(txt);
          send_text(txt);
        end
      end
      if (beats_sent >= next_drain) begin
        drain();
        next_drain = beats_sent + $urandom_range(150, 300);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
